@@ hdl/pscu_pkg.sv @@
`default_nettype none
package pscu_pkg;
	localparam int FRAC_BITS = 16;
	localparam int RAD_FRAC = 28;
	localparam logic [31:0] K_DEG2RAD = 32'd74961321;
	localparam logic signed [33:0] HALF_PI = 34'sd421657426;
	localparam logic signed [33:0] PI_Q = 34'sd843314856;
	localparam logic signed [33:0] TWO_PI = 34'sd1686629714;
	localparam logic signed [33:0] PARAB_B = 34'sd341782637;
	localparam logic signed [33:0] PARAB_C = 34'sd108792793;
	localparam logic signed [33:0] CORR_P = 34'sd60397978;
	localparam logic signed [47:0] VAL_MAX = 48'sh7FFFFFFFFFFF;
	localparam logic signed [47:0] VAL_MIN = 48'sh800000000000;
	localparam logic [47:0] TAN90_VAL = 48'(64'd2000000000 << FRAC_BITS);
	localparam logic signed [31:0] FULL = 32'sd360 <<< FRAC_BITS;
	localparam logic signed [31:0] ANG90 = 32'sd90 <<< FRAC_BITS;

	localparam logic [1:0] OP_SIN = 2'd0;
	localparam logic [1:0] OP_COS = 2'd1;
	localparam logic [1:0] OP_TAN = 2'd2;

	// datapath commands
	localparam logic [3:0] C_NOP   = 4'd0;
	localparam logic [3:0] C_LOAD  = 4'd1;
	localparam logic [3:0] C_RED   = 4'd2;
	localparam logic [3:0] C_RAD   = 4'd3;
	localparam logic [3:0] C_WRAP  = 4'd4;
	localparam logic [3:0] C_M1    = 4'd5;
	localparam logic [3:0] C_M2    = 4'd6;
	localparam logic [3:0] C_M3    = 4'd7;
	localparam logic [3:0] C_M4    = 4'd8;
	localparam logic [3:0] C_M5    = 4'd9;
	localparam logic [3:0] C_SAVE  = 4'd10;
	localparam logic [3:0] C_DIVI  = 4'd11;
	localparam logic [3:0] C_DIVS  = 4'd12;
	localparam logic [3:0] C_FIN   = 4'd13;
	localparam logic [3:0] C_COSX  = 4'd14;

	typedef struct packed {
		logic [3:0] cmd;
	} ctl_t;

	typedef struct packed {
		logic red_done;
		logic div_done;
		logic is_tan;
		logic tan90;
		logic pole;
	} sts_t;

	// round half away from zero right shift of a signed 96-bit value
	function automatic logic signed [95:0] rshr(input logic signed [95:0] v,
		input int n);
		logic [95:0] m;
		begin
			m = v[95] ? 96'(-v) : 96'(v);
			m = (m + (96'd1 << (n - 1))) >> n;
			rshr = v[95] ? -$signed(m) : $signed(m);
		end
	endfunction
endpackage
`default_nettype wire

@@ hdl/pscu_ctrl.sv @@
`default_nettype none
module pscu_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	input  wire logic out_fire,
	input  wire pscu_pkg::sts_t sts,
	output pscu_pkg::ctl_t ctl,
	output logic busy,
	output logic out_valid
);
	import pscu_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0, S_RED = 4'd1, S_RAD = 4'd2, S_WRAP = 4'd3,
		S_M1 = 4'd4, S_M2 = 4'd5, S_M3 = 4'd6, S_M4 = 4'd7, S_M5 = 4'd8,
		S_SAVE = 4'd9, S_DIVI = 4'd10, S_DIVS = 4'd11, S_FIN = 4'd12, S_OUT = 4'd13;

	logic [3:0] state_q, state_d;
	logic pass_q, pass_d;

	// sequence the steps; second pass computes cosine for tangent
	always_comb begin
		state_d = state_q;
		pass_d = pass_q;
		ctl.cmd = C_NOP;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					ctl.cmd = C_LOAD;
					state_d = S_RED;
					pass_d = 1'b0;
				end
			end
			S_RED: begin
				ctl.cmd = C_RED;
				if (sts.red_done) state_d = S_RAD;
			end
			S_RAD: begin
				ctl.cmd = C_RAD;
				state_d = S_WRAP;
			end
			S_WRAP: begin
				ctl.cmd = C_WRAP;
				state_d = S_M1;
			end
			S_M1: begin ctl.cmd = C_M1; state_d = S_M2; end
			S_M2: begin ctl.cmd = C_M2; state_d = S_M3; end
			S_M3: begin ctl.cmd = C_M3; state_d = S_M4; end
			S_M4: begin ctl.cmd = C_M4; state_d = S_M5; end
			S_M5: begin
				ctl.cmd = C_M5;
				state_d = S_SAVE;
			end
			S_SAVE: begin
				if (sts.is_tan && !sts.tan90 && !pass_q) begin
					ctl.cmd = C_COSX;
					pass_d = 1'b1;
					state_d = S_M1;
				end else if (sts.is_tan && !sts.tan90) begin
					ctl.cmd = C_SAVE;
					state_d = S_DIVI;
				end else begin
					ctl.cmd = C_FIN;
					state_d = S_OUT;
				end
			end
			S_DIVI: begin
				if (sts.pole) begin
					ctl.cmd = C_FIN;
					state_d = S_OUT;
				end else begin
					ctl.cmd = C_DIVI;
					state_d = S_DIVS;
				end
			end
			S_DIVS: begin
				ctl.cmd = C_DIVS;
				if (sts.div_done) state_d = S_FIN;
			end
			S_FIN: begin
				ctl.cmd = C_FIN;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_fire) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pass_q <= pass_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
endmodule
`default_nettype wire

@@ hdl/pscu_dp.sv @@
`default_nettype none
module pscu_dp (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire pscu_pkg::ctl_t ctl,
	input  wire logic [1:0] req_type,
	input  wire logic signed [31:0] angle_deg,
	output pscu_pkg::sts_t sts,
	output logic [47:0] value,
	output logic pole
);
	import pscu_pkg::*;

	logic [1:0] op_q;
	logic signed [31:0] ang_q;
	logic signed [32:0] red_q;
	logic [2:0] fk_q;
	logic signed [33:0] rad_q, x_q, ax_q, s_q, as_q, t_q, sn_q;
	logic signed [33:0] cs_q;
	logic [47:0] value_q;
	logic pole_q;
	logic [63:0] rem_q;
	logic [47:0] quo_q;
	logic [33:0] mc_q;
	logic neg_q;
	logic [6:0] cnt_q;

	logic signed [95:0] p;
	logic signed [33:0] ma, mb, xw, xin;
	logic mag_neg;
	logic [32:0] mag;
	logic [32:0] fold_sub;
	logic div_bit;
	logic [64:0] trial;

	// dividend bit i of |sn|<<F + mc/2
	function automatic logic dvd_bit(input logic [6:0] i);
		logic [63:0] d;
		begin
			d = ({30'd0, (sn_q[33] ? 34'(-sn_q) : 34'(sn_q))} << FRAC_BITS)
				+ 64'(mc_q >> 1);
			dvd_bit = d[i[5:0]];
		end
	endfunction

	// magnitude of the reduced angle, folded by 360 times a power of two per step
	assign mag_neg = red_q[32];
	assign mag = mag_neg ? 33'(-red_q) : 33'(red_q);
	assign fold_sub = 33'(FULL) << fk_q;
	assign sts.red_done = (mag <= 33'(FULL));
	assign sts.is_tan = (op_q == OP_TAN);
	assign sts.tan90 = (ang_q == ANG90);
	assign sts.pole = (cs_q == 34'sd0);
	assign sts.div_done = (cnt_q == 7'd0);

	// shared multiplier operands
	always_comb begin
		ma = '0;
		mb = '0;
		case (ctl.cmd)
			C_M1: begin ma = x_q; mb = ax_q; end
			C_M2: begin ma = PARAB_C; mb = t_q; end
			C_M4: begin ma = s_q; mb = as_q; end
			C_M5: begin ma = CORR_P; mb = t_q; end
			default: begin ma = PARAB_B; mb = x_q; end
		endcase
		p = 96'(ma) * 96'(mb);
	end

	// wrap input: radians, plus a quarter turn for cosine
	always_comb begin
		xin = rad_q;
		if (op_q == OP_COS || ctl.cmd == C_COSX) xin = rad_q + HALF_PI;
		xw = xin;
		if (xin < -PI_Q) xw = xin + TWO_PI;
		else if (xin > PI_Q) xw = xin - TWO_PI;
	end

	// restoring divider step: shift in the next dividend bit, then compare
	assign div_bit = dvd_bit(cnt_q - 7'd1);
	assign trial = {rem_q, div_bit} - {31'd0, mc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= '0;
			ang_q <= '0;
			red_q <= '0;
			fk_q <= '0;
			rad_q <= '0;
			x_q <= '0;
			ax_q <= '0;
			s_q <= '0;
			as_q <= '0;
			t_q <= '0;
			sn_q <= '0;
			cs_q <= '0;
			value_q <= '0;
			pole_q <= 1'b0;
			rem_q <= '0;
			quo_q <= '0;
			mc_q <= '0;
			neg_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			case (ctl.cmd)
				C_LOAD: begin
					op_q <= req_type;
					ang_q <= angle_deg;
					red_q <= 33'(angle_deg);
					fk_q <= 3'd6;
					pole_q <= 1'b0;
				end
				C_RED: begin
					// remove 360 * 2^k toward zero while more than a turn remains
					if (!sts.red_done) begin
						if (mag > fold_sub)
							red_q <= mag_neg ? red_q + $signed(fold_sub)
								: red_q - $signed(fold_sub);
						if (fk_q != 3'd0) fk_q <= fk_q - 3'd1;
					end
				end
				C_RAD: rad_q <= 34'(rshr(96'(red_q) * 96'(K_DEG2RAD),
					FRAC_BITS + 32 - RAD_FRAC));
				C_WRAP, C_COSX: begin
					x_q <= xw;
					ax_q <= xw[33] ? -xw : xw;
					if (ctl.cmd == C_COSX) sn_q <= t_q + s_q;
				end
				C_M1: begin
					s_q <= 34'(rshr(96'(PARAB_B) * 96'(x_q), RAD_FRAC));
					t_q <= 34'(rshr(p, RAD_FRAC));
				end
				C_M2: t_q <= 34'(rshr(p, RAD_FRAC));
				C_M3: begin
					s_q <= s_q - t_q;
					as_q <= (s_q - t_q) < 0 ? -(s_q - t_q) : (s_q - t_q);
				end
				C_M4: t_q <= 34'(rshr(p, RAD_FRAC)) - s_q;
				C_M5: t_q <= 34'(rshr(p, RAD_FRAC));
				C_SAVE: cs_q <= t_q + s_q;
				C_DIVI: begin
					// dividend: |sn|<<F + |cs|/2, shifted in MSB first
					rem_q <= '0;
					quo_q <= '0;
					mc_q <= cs_q[33] ? 34'(-cs_q) : 34'(cs_q);
					neg_q <= sn_q[33] ^ cs_q[33];
					cnt_q <= 7'd64;
					t_q <= '0;
				end
				C_DIVS: begin
					if (cnt_q != 7'd0) begin
						cnt_q <= cnt_q - 7'd1;
						if (quo_q[47]) t_q <= 34'sd1;
						if (!trial[64]) begin
							rem_q <= trial[63:0];
							quo_q <= {quo_q[46:0], 1'b1};
						end else begin
							rem_q <= {rem_q[62:0], div_bit};
							quo_q <= {quo_q[46:0], 1'b0};
						end
					end
				end
				C_FIN: begin
					if (op_q == OP_TAN && sts.tan90) value_q <= TAN90_VAL;
					else if (op_q == OP_TAN && sts.pole) begin
						pole_q <= 1'b1;
						value_q <= sn_q[33] ? VAL_MIN : VAL_MAX;
					end else if (op_q == OP_TAN) begin
						if (t_q != 0 || quo_q[47])
							value_q <= neg_q ? VAL_MIN : VAL_MAX;
						else
							value_q <= neg_q ? -quo_q : quo_q;
					end else if (op_q == OP_SIN || op_q == OP_COS)
						value_q <= 48'(rshr(96'(t_q + s_q), RAD_FRAC - FRAC_BITS));
					else value_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assign value = value_q;
	assign pole = pole_q;
endmodule
`default_nettype wire

@@ hdl/parabolic_sin_cos_tan_unit.sv @@
// Sequence: after the accepting edge the angle is folded by 360 (one compare
// per power-of-two turn), converted to radians and wrapped, and the corrected
// parabola is evaluated; tangent, but for exactly 90, repeats this for cosine
// and runs the 64-step divider, skipped at a tangent pole. Handshake: one
// request at a time; tready returns the cycle after the result is taken.
// Reset: arst_n asynchronous active low returns the controller to idle.
`default_nettype none
module parabolic_sin_cos_tan_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [39:0] s_axis_tdata, // [1:0] req_type, [33:2] angle_deg
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [55:0] m_axis_tdata // [47:0] value, [48] pole
);
	import pscu_pkg::*;

	ctl_t ctl;
	sts_t sts;
	logic busy, in_fire, out_fire, pole;
	logic [47:0] value;

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	pscu_ctrl u_ctrl (.clk, .arst_n, .in_fire, .out_fire, .sts, .ctl, .busy,
		.out_valid(m_axis_tvalid));

	pscu_dp u_dp (.clk, .arst_n, .ctl, .req_type(s_axis_tdata[1:0]),
		.angle_deg(s_axis_tdata[33:2]), .sts, .value, .pole);

	assign m_axis_tdata = {7'd0, pole, value};
endmodule
`default_nettype wire

@@ bench/parabolic_sin_cos_tan_unit_tb.sv @@
`default_nettype none
module parabolic_sin_cos_tan_unit_tb;
	import pscu_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int N_RANDOM = 1330;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam longint DEG = 64'sd1 <<< FRAC_BITS;
	localparam logic [47:0] TAN90_EXPECT = 48'd131072000000000;

	typedef struct {
		logic [47:0] value;
		logic pole;
	} result_t;

	typedef struct {
		logic [1:0] op;
		logic [31:0] angle;
		bit typed;
		logic [47:0] value;
		logic pole;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;

	result_t pending_results[$];
	int errors = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	bit hold_request = 1'b0;
	int hold_count = 0;
	int quiet_cycles = 0;

	parabolic_sin_cos_tan_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	// shift right, rounding half away from zero
	function automatic longint round_shift(longint v, int n);
		longint unsigned m;
		m = v < 0 ? longint'(-v) : longint'(v);
		if (n > 0)
			m = (m + (64'd1 << (n - 1))) >> n;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint mul_q28(longint a, longint b);
		return round_shift(a * b, RAD_FRAC);
	endfunction

	// fold into -360..360 and convert to Q3.28 radians
	function automatic longint fold_to_radians(longint a);
		longint full;
		full = 64'sd360 <<< FRAC_BITS;
		if (a > full)
			a = (a - 1) % full + 1;
		else if (a < -full)
			a = -((-a - 1) % full + 1);
		return round_shift(a * longint'(K_DEG2RAD), FRAC_BITS + 32 - RAD_FRAC);
	endfunction

	// wrap once, then corrected parabola
	function automatic longint parabola_sine(longint x);
		longint s, ax, as_;
		if (x < -longint'(PI_Q))
			x += longint'(TWO_PI);
		else if (x > longint'(PI_Q))
			x -= longint'(TWO_PI);
		ax = x < 0 ? -x : x;
		s = mul_q28(longint'(PARAB_B), x) - mul_q28(longint'(PARAB_C), mul_q28(x, ax));
		as_ = s < 0 ? -s : s;
		return mul_q28(longint'(CORR_P), mul_q28(s, as_) - s) + s;
	endfunction

	function automatic result_t predict_trig(logic [1:0] op, logic [31:0] angle);
		result_t r;
		longint ang, rad, sn, cs, q;
		longint unsigned ms, mc;
		bit neg;
		ang = longint'($signed(angle));
		rad = fold_to_radians(ang);
		r.value = '0;
		r.pole = 1'b0;
		case (op)
			OP_SIN: r.value = 48'(round_shift(parabola_sine(rad), RAD_FRAC - FRAC_BITS));
			OP_COS: r.value = 48'(round_shift(parabola_sine(rad + longint'(HALF_PI)),
				RAD_FRAC - FRAC_BITS));
			OP_TAN: begin
				if (ang == 90 * DEG) begin
					r.value = 48'(64'sd2000000000 <<< FRAC_BITS);
				end else begin
					sn = parabola_sine(rad);
					cs = parabola_sine(rad + longint'(HALF_PI));
					if (cs == 0) begin
						r.pole = 1'b1;
						r.value = sn >= 0 ? VAL_MAX : VAL_MIN;
					end else begin
						ms = sn < 0 ? longint'(-sn) : longint'(sn);
						mc = cs < 0 ? longint'(-cs) : longint'(cs);
						q = longint'(((ms << FRAC_BITS) + mc / 2) / mc);
						neg = (sn < 0) != (cs < 0);
						if (longint'(q) > longint'(VAL_MAX))
							r.value = neg ? VAL_MIN : VAL_MAX;
						else
							r.value = 48'(neg ? -q : q);
					end
				end
			end
			default: r.value = '0;
		endcase
		return r;
	endfunction

	// offer one request, idling first as the phase asks
	task automatic send_request(logic [1:0] op, logic [31:0] angle, result_t expect_r);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, angle, op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_results.push_back(expect_r);
	endtask

	task automatic send_checked(logic [1:0] op, logic [31:0] angle);
		send_request(op, angle, predict_trig(op, angle));
	endtask

	function automatic logic [31:0] random_angle();
		case ($urandom_range(9))
			0, 1: return $urandom;
			2, 3, 4: return 32'($signed($urandom_range(1440)) - 720) * 32'(DEG)
				+ 32'($urandom_range(65535));
			5: return 32'(($signed($urandom_range(16)) - 8) * 90) * 32'(DEG);
			6: return $urandom_range(1) ? 32'(360 * DEG) : -32'(360 * DEG);
			7: return 32'(90 * DEG) + 32'($signed($urandom_range(2)) - 1);
			8: return 32'($signed($urandom_range(8)) - 4) * 32'(360 * DEG)
				+ 32'($signed($urandom_range(4)) - 2);
			default: return 32'($signed($urandom_range(200000)) - 100000);
		endcase
	endfunction

	function automatic logic [1:0] random_op();
		return $urandom_range(19) == 0 ? OP_NONE : 2'($urandom_range(2));
	endfunction

	// directed table; typed rows carry their own expectation
	stim_row_t directed[] = '{
		'{OP_SIN, 32'd0, 1'b1, 48'd0, 1'b0},
		'{OP_TAN, 32'd0, 1'b1, 48'd0, 1'b0},
		'{OP_TAN, 32'(90 * DEG), 1'b1, TAN90_EXPECT, 1'b0},
		'{OP_NONE, 32'h12345678, 1'b1, 48'd0, 1'b0},
		'{OP_NONE, 32'h80000000, 1'b1, 48'd0, 1'b0},
		'{OP_COS, 32'd0, 1'b0, 48'd0, 1'b0},
		'{OP_SIN, 32'(90 * DEG), 1'b0, 48'd0, 1'b0},
		'{OP_COS, 32'(90 * DEG), 1'b0, 48'd0, 1'b0},
		'{OP_SIN, 32'(360 * DEG), 1'b0, 48'd0, 1'b0},
		'{OP_SIN, -32'(360 * DEG), 1'b0, 48'd0, 1'b0},
		'{OP_COS, 32'(360 * DEG) + 32'd1, 1'b0, 48'd0, 1'b0},
		'{OP_COS, -32'(360 * DEG) - 32'd1, 1'b0, 48'd0, 1'b0},
		'{OP_SIN, 32'h7FFFFFFF, 1'b0, 48'd0, 1'b0},
		'{OP_COS, 32'h80000000, 1'b0, 48'd0, 1'b0},
		'{OP_TAN, 32'h7FFFFFFF, 1'b0, 48'd0, 1'b0},
		'{OP_TAN, 32'h80000000, 1'b0, 48'd0, 1'b0},
		'{OP_TAN, -32'(90 * DEG), 1'b0, 48'd0, 1'b0},
		'{OP_TAN, 32'(450 * DEG), 1'b0, 48'd0, 1'b0},
		'{OP_TAN, 32'(90 * DEG) + 32'd1, 1'b0, 48'd0, 1'b0},
		'{OP_TAN, 32'(270 * DEG), 1'b0, 48'd0, 1'b0},
		'{OP_SIN, 32'(180 * DEG), 1'b0, 48'd0, 1'b0},
		'{OP_COS, -32'(180 * DEG), 1'b0, 48'd0, 1'b0},
		'{OP_TAN, 32'(45 * DEG), 1'b0, 48'd0, 1'b0},
		'{OP_SIN, 32'hFFFFFFFF, 1'b0, 48'd0, 1'b0}
	};

	// stimulus
	initial begin
		result_t r;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			if (directed[i].typed) begin
				r.value = directed[i].value;
				r.pole = directed[i].pole;
				send_request(directed[i].op, directed[i].angle, r);
			end else begin
				send_checked(directed[i].op, directed[i].angle);
			end
		end
		// fill the block while the receiver holds off
		hold_request = 1'b1;
		for (int i = 0; i < 20; i++)
			send_checked(random_op(), random_angle());
		// pause until everything has drained
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		for (int phase = 0; phase < 4; phase++) begin
			sender_idle_pct = (phase == 1) ? 46 : (phase == 3) ? 14 : 0;
			receiver_stall_pct = (phase == 2) ? 46 : (phase == 3) ? 14 : 0;
			for (int i = 0; i < N_RANDOM / 4; i++)
				send_checked(random_op(), random_angle());
		end
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// drive ready and check each result
	always @(posedge clk) begin
		result_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_axis_tdata);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (m_axis_tdata[47:0] !== e.value) begin
					$display("%0t: value expected %h actual %h", $time, e.value,
						m_axis_tdata[47:0]);
					errors++;
				end
				if (m_axis_tdata[48] !== e.pole) begin
					$display("%0t: pole expected %b actual %b", $time, e.pole,
						m_axis_tdata[48]);
					errors++;
				end
			end
		end
		if (hold_request && hold_count < HOLD_CYCLES) begin
			hold_count <= hold_count + 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= arst_n && ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// abort when nothing moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end
endmodule
`default_nettype wire
